### rtl/sshdf_pkg.sv
// sshdf_pkg: shared types and constants of the ssh transport deframer
// used by ssh_transport_deframer_core and its port checker
// no dependencies
package sshdf_pkg;

  // event kinds, carried on m_axis_tuser
  typedef enum logic [2:0] {
    EV_VERSION  = 3'd0,
    EV_KEXINIT  = 3'd1,
    EV_NEWKEYS  = 3'd2,
    EV_KEX_REC  = 3'd3,
    EV_KEX_DROP = 3'd4,
    EV_OTHER    = 3'd5,
    EV_ERROR    = 3'd6
  } ev_kind_e;

  // deframer phases, one-hot
  typedef enum logic [4:0] {
    PH_PREFIX  = 5'b00001,
    PH_NEWLINE = 5'b00010,
    PH_HEADER  = 5'b00100,
    PH_BODY    = 5'b01000,
    PH_LOCKED  = 5'b10000
  } phase_e;

  // configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_ENABLE  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_MAX_LEN = 2'd1;

  localparam int unsigned LenW      = 24;
  localparam int unsigned TotalW    = 25;
  localparam int unsigned HdrW      = 48;
  localparam int unsigned InDataW   = 8;
  localparam int unsigned OutDataW  = 64;
  localparam int unsigned OutUserW  = 3;

  localparam logic [LenW-1:0] MAX_LEN_RESET = 24'd32768;

  localparam logic [7:0] CHAR_S  = 8'h53;
  localparam logic [7:0] CHAR_H  = 8'h48;
  localparam logic [7:0] CHAR_DASH = 8'h2D;
  localparam logic [7:0] CHAR_LF = 8'h0A;

  localparam logic [7:0] MSG_KEXINIT = 8'd20;
  localparam logic [7:0] MSG_NEWKEYS = 8'd21;
  localparam logic [7:0] MSG_KEX_LO  = 8'd30;
  localparam logic [7:0] MSG_KEX_HI  = 8'd49;

  // bit positions of the result fields in m_axis_tdata
  localparam int unsigned TdCodeLsb  = 0;
  localparam int unsigned TdTotalLsb = 8;
  localparam int unsigned TdPlenLsb  = 33;
  localparam int unsigned TdSlotLsb  = 57;

  typedef struct packed {
    ev_kind_e          kind;
    logic [7:0]        code;
    logic [TotalW-1:0] total;
    logic [LenW-1:0]   plen;
    logic [2:0]        slot;
  } result_t;

  // expected character of the version prefix "SSH-"
  function automatic logic [7:0] prefix_char(input logic [1:0] pos);
    logic [7:0] c;
    case (pos)
      2'd0:    c = CHAR_S;
      2'd1:    c = CHAR_S;
      2'd2:    c = CHAR_H;
      default: c = CHAR_DASH;
    endcase
    return c;
  endfunction

endpackage

### rtl/ssh_transport_deframer_core.sv
// ssh_transport_deframer_core: byte-serial ssh version line and binary packet deframer
// depends on sshdf_pkg
// checked by sshdf_checker (bound in its own file)
//
// usage: one byte of the tcp application stream per s_axis transaction.
// the block hunts for "SSH-" (with kmp style restart), then for the newline that
// closes the version line, then frames binary packets (4 byte length, padding
// byte, message code, body). it emits at most one event per byte on m_axis:
// version end, kexinit, newkeys, kex recorded/dropped, other, framing error.
// config writes (enable, max_payload_len) arrive on the cfg channel, always ready.
// output: each event is registered in the event register, or in the skid register
// when that one is occupied. throughput: one byte per cycle while s_axis_tready is
// high; all work for a byte is one pass of header shift, length check and counter
// logic between the input edge and the event register.
// stall: a skid register behind the event register holds one more event, so
// bytes keep flowing while one event waits; s_axis_tready drops only while the
// skid register is occupied.
// reset: enable=1, max_payload_len=32768, prefix hunt restarts, kex table empty.
// a framing error locks the deframer until reset.
module ssh_transport_deframer_core #(
  parameter int unsigned KEX_TABLE_DEPTH = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // stream input, tdata: data_byte[7:0]
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [sshdf_pkg::InDataW-1:0]     s_axis_tdata,
  // event output
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: code_byte[7:0], packet_total[32:8], payload_length[56:33],
  //        kex_slot[59:57], zero[63:60]
  output logic [sshdf_pkg::OutDataW-1:0]    m_axis_tdata,
  // tuser: event_kind[2:0]
  output logic [sshdf_pkg::OutUserW-1:0]    m_axis_tuser,
  // configuration write channel
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sshdf_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [sshdf_pkg::LenW-1:0]        cfg_data_i
);
  import sshdf_pkg::*;

  localparam int unsigned KexCntW = $clog2(KEX_TABLE_DEPTH + 1);
  localparam logic [KexCntW-1:0] KexDepth = KexCntW'(KEX_TABLE_DEPTH);

  // configuration
  logic            enable_q;
  logic [LenW-1:0] max_len_q;

  // deframer state
  phase_e             phase_q, phase_d;
  logic [1:0]         prefix_q, prefix_d;
  logic [HdrW-1:0]    hdr_q, hdr_d;
  logic [2:0]         hdr_cnt_q, hdr_cnt_d;
  logic [LenW-1:0]    remain_q, remain_d;
  logic [KexCntW-1:0] kex_cnt_q, kex_cnt_d;

  // event and skid registers
  result_t out_q, out_d, skid_q, skid_d;
  logic    out_valid_q, out_valid_d, skid_valid_q, skid_valid_d;

  logic       in_xact;
  logic       out_xact;
  logic       ev_valid;
  result_t    ev;

  // header view used for checks and packet end
  logic [HdrW-1:0] hdr_shift;
  logic [HdrW-1:0] hdr_fin;
  logic [31:0]     len_w, plen_w, fin_len, fin_plen;
  logic            hdr_bad;
  logic            finish;
  logic [7:0]      fin_code;
  logic [7:0]      b;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !skid_valid_q;
  assign in_xact       = s_axis_tvalid && s_axis_tready;
  assign out_xact      = out_valid_q && m_axis_tready;
  assign b             = s_axis_tdata;

  assign hdr_shift = {hdr_q[HdrW-9:0], b};
  assign len_w     = hdr_shift[47:16];
  assign plen_w    = len_w - {24'd0, hdr_shift[15:8]} + 32'd5;
  assign hdr_bad   = (len_w < 32'd2) || (len_w > {8'd0, max_len_q}) ||
                     (plen_w == 32'd0) || (plen_w > {8'd0, max_len_q});

  // packet end on the sixth header byte uses the fresh header
  assign hdr_fin  = (phase_q == PH_HEADER) ? hdr_shift : hdr_q;
  assign fin_len  = hdr_fin[47:16];
  assign fin_plen = fin_len - {24'd0, hdr_fin[15:8]} + 32'd5;
  assign fin_code = hdr_fin[7:0];

  // per-byte state update
  always_comb begin
    phase_d   = phase_q;
    prefix_d  = prefix_q;
    hdr_d     = hdr_q;
    hdr_cnt_d = hdr_cnt_q;
    remain_d  = remain_q;
    kex_cnt_d = kex_cnt_q;
    ev_valid  = 1'b0;
    ev        = '{kind: EV_VERSION, code: 8'd0, total: '0, plen: '0, slot: 3'd0};
    finish    = 1'b0;

    if (in_xact && enable_q) begin
      case (phase_q)
        PH_PREFIX: begin
          if (b == prefix_char(prefix_q)) begin
            if (prefix_q == 2'd3) begin
              prefix_d = 2'd0;
              phase_d  = PH_NEWLINE;
            end else begin
              prefix_d = prefix_q + 2'd1;
            end
          end else if (prefix_q == 2'd2 && b == CHAR_S) begin
            prefix_d = 2'd2;
          end else if (b == CHAR_S) begin
            prefix_d = 2'd1;
          end else begin
            prefix_d = 2'd0;
          end
        end
        PH_NEWLINE: begin
          if (b == CHAR_LF) begin
            phase_d   = PH_HEADER;
            hdr_cnt_d = 3'd0;
            hdr_d     = '0;
            ev_valid  = 1'b1;
          end
        end
        PH_HEADER: begin
          hdr_d = hdr_shift;
          if (hdr_cnt_q == 3'd5) begin
            hdr_cnt_d = 3'd0;
            if (hdr_bad) begin
              phase_d  = PH_LOCKED;
              ev_valid = 1'b1;
              ev.kind  = EV_ERROR;
              ev.code  = b;
            end else if (len_w[LenW-1:0] == LenW'(2)) begin
              finish = 1'b1;
            end else begin
              remain_d = len_w[LenW-1:0] - LenW'(2);
              phase_d  = PH_BODY;
            end
          end else begin
            hdr_cnt_d = hdr_cnt_q + 3'd1;
          end
        end
        PH_BODY: begin
          remain_d = remain_q - LenW'(1);
          if (remain_q == LenW'(1)) begin
            finish = 1'b1;
          end
        end
        default: begin
          // locked: bytes are dropped until reset
        end
      endcase

      if (finish) begin
        ev_valid  = 1'b1;
        ev.code   = fin_code;
        ev.total  = TotalW'({1'b0, fin_len[LenW-1:0]} + 25'd4);
        ev.plen   = fin_plen[LenW-1:0];
        phase_d   = PH_HEADER;
        hdr_cnt_d = 3'd0;
        hdr_d     = '0;
        remain_d  = '0;
        if (fin_code == MSG_KEXINIT) begin
          ev.kind = EV_KEXINIT;
        end else if (fin_code == MSG_NEWKEYS) begin
          ev.kind = EV_NEWKEYS;
        end else if (fin_code >= MSG_KEX_LO && fin_code <= MSG_KEX_HI) begin
          if (kex_cnt_q < KexDepth) begin
            ev.kind   = EV_KEX_REC;
            ev.slot   = 3'(kex_cnt_q);
            kex_cnt_d = kex_cnt_q + KexCntW'(1);
          end else begin
            ev.kind = EV_KEX_DROP;
          end
        end else begin
          ev.kind = EV_OTHER;
        end
      end
    end
  end

  // event register with one-deep skid behind it
  always_comb begin
    out_d        = out_q;
    skid_d       = skid_q;
    out_valid_d  = out_valid_q;
    skid_valid_d = skid_valid_q;
    if (out_xact) begin
      if (skid_valid_q) begin
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = 1'b0;
      end
    end
    if (ev_valid) begin
      if (!out_valid_q || (out_xact && !skid_valid_q)) begin
        out_d       = ev;
        out_valid_d = 1'b1;
      end else begin
        skid_d       = ev;
        skid_valid_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q     <= 1'b1;
      max_len_q    <= MAX_LEN_RESET;
      phase_q      <= PH_PREFIX;
      prefix_q     <= 2'd0;
      hdr_q        <= '0;
      hdr_cnt_q    <= 3'd0;
      remain_q     <= '0;
      kex_cnt_q    <= '0;
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_ENABLE:  enable_q  <= cfg_data_i[0];
          CFG_MAX_LEN: max_len_q <= cfg_data_i;
          default: begin
            // writes beyond the register list are dropped
          end
        endcase
      end
      phase_q      <= phase_d;
      prefix_q     <= prefix_d;
      hdr_q        <= hdr_d;
      hdr_cnt_q    <= hdr_cnt_d;
      remain_q     <= remain_d;
      kex_cnt_q    <= kex_cnt_d;
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  // event payload, no reset needed
  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tdata  = {4'd0, out_q.slot, out_q.plen, out_q.total, out_q.code};

endmodule

### rtl/sshdf_checker.sv
// sshdf_checker: port-level assertions for ssh_transport_deframer_core
// depends on sshdf_pkg; bound to the top level at the end of this file
module sshdf_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tready,
  input logic                           m_axis_tvalid,
  input logic                           m_axis_tready,
  input logic [sshdf_pkg::OutDataW-1:0] m_axis_tdata,
  input logic [sshdf_pkg::OutUserW-1:0] m_axis_tuser
);
  import sshdf_pkg::*;

  logic err_seen_q;

  // remembers a delivered framing error
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      err_seen_q <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser == EV_ERROR) begin
      err_seen_q <= 1'b1;
    end
  end

  // the deframer is locked after a framing error: no later event
  a_locked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_seen_q |-> !m_axis_tvalid)
    else $error("event after framing error");

  // input back-pressure only while an event is pending on the output
  a_stall_only_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> m_axis_tvalid)
    else $error("input stalled with empty output");

  // only a recorded kex event carries a table slot
  a_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != EV_KEX_REC) |-> (m_axis_tdata[59:57] == 3'd0))
    else $error("kex slot on non-kex event");

  // version end and framing error carry no lengths
  a_no_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tuser == EV_VERSION || m_axis_tuser == EV_ERROR))
      |-> (m_axis_tdata[56:8] == 49'd0))
    else $error("lengths on version or error event");

  // event kind stays within the defined codes
  a_kind_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser <= EV_ERROR))
    else $error("undefined event kind");

endmodule

bind ssh_transport_deframer_core sshdf_checker u_sshdf_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata),
  .m_axis_tuser (m_axis_tuser)
);
